@@ design/frc_pkg.sv @@
// Shared constants and types for the frame receiver with CRC checks and classifier.
`default_nettype none

package frc_pkg;

   // Framing and CRC constants.
   localparam logic [7:0]  StartByte  = 8'h3D;
   localparam logic [7:0]  Crc8Poly   = 8'h39;
   localparam logic [7:0]  Crc8Init   = 8'h66;
   localparam logic [15:0] Crc16Poly  = 16'h1021;
   localparam logic [15:0] Crc16Init  = 16'h913D;
   localparam logic [7:0]  FormShort  = 8'hC5;
   localparam logic [7:0]  FormLong   = 8'h05;
   localparam logic [7:0]  DefaultLen = 8'd6;

   // Header byte positions.
   localparam logic [7:0] PosForm       = 8'd1;
   localparam logic [7:0] PosLenShort   = 8'd2;
   localparam logic [7:0] PosCrcShort   = 8'd3;
   localparam logic [7:0] PosLenLong    = 8'd4;
   localparam logic [7:0] PosCrcLong    = 8'd6;
   localparam logic [7:0] PosKind       = 8'd4;
   localparam logic [7:0] PosTypeLow    = 8'd11;
   localparam logic [7:0] PosTypeHigh   = 8'd12;

   // Short-form kind bytes.
   localparam logic [7:0] KindFirst  = 8'h03;
   localparam logic [7:0] KindLast   = 8'h08;
   localparam logic [7:0] KindSpecial = 8'h20;

   // Long-form type words.
   localparam logic [15:0] TypeA = 16'h021A;
   localparam logic [15:0] TypeB = 16'h0211;
   localparam logic [15:0] TypeC = 16'h0218;
   localparam logic [15:0] TypeD = 16'h0103;
   localparam logic [15:0] TypeE = 16'h0402;

   // Packet class codes.
   localparam logic [3:0] ClassNone     = 4'd0;
   localparam logic [3:0] ClassKindBias = 4'd2;
   localparam logic [3:0] ClassSpecial  = 4'd7;
   localparam logic [3:0] ClassTypeA    = 4'd8;
   localparam logic [3:0] ClassTypeB    = 4'd9;
   localparam logic [3:0] ClassTypeC    = 4'd10;
   localparam logic [3:0] ClassTypeD    = 4'd11;
   localparam logic [3:0] ClassTypeE    = 4'd12;
   localparam logic [3:0] ClassOther    = 4'd13;

   // Depth of the queue between the parser and the classifier.
   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCountW = $clog2(QueueDepth + 1);

   // Completed frame as handed from the parser to the classifier.
   typedef struct packed {
      logic [7:0]  frame_length;
      logic        crc16_ok;
      logic [7:0]  command_byte;
      logic [7:0]  kind_byte;
      logic [15:0] type_word;
   } frame_rec_type;

   // Queue occupancy status.
   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QueueCountW-1:0] count;
   } queue_status_type;

endpackage

`default_nettype wire

@@ design/frc_front.sv @@
// Frame parser: tracks byte position, checks the header CRC8 and runs the frame CRC16.
`default_nettype none

module frc_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                byte_valid,
   input  wire logic [7:0]          rx_byte,
   output logic                     rec_valid,
   output frc_pkg::frame_rec_type   rec
);

   // One byte of CRC8, MSB first.
   function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ frc_pkg::Crc8Poly) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // One byte of CRC16, MSB first.
   function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ frc_pkg::Crc16Poly) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  exp_len_ff, exp_len_in;
   logic        short_ff, short_in;
   logic [7:0]  hcrc_ff, hcrc_in;
   logic [15:0] fcrc_ff, fcrc_in;
   logic [15:0] last_ff, last_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] type_ff, type_in;
   logic        rec_valid_ff, rec_valid_in;
   frc_pkg::frame_rec_type rec_ff, rec_in;

   logic [7:0] len_at;
   logic [7:0] crc_at;
   logic [8:0] count;

   // Next state for one accepted byte.
   always_comb begin
      pos_in       = pos_ff;
      exp_len_in   = exp_len_ff;
      short_in     = short_ff;
      hcrc_in      = hcrc_ff;
      fcrc_in      = fcrc_ff;
      last_in      = last_ff;
      kind_in      = kind_ff;
      cmd_in       = cmd_ff;
      type_in      = type_ff;
      rec_valid_in = 1'b0;
      rec_in       = rec_ff;
      len_at       = frc_pkg::PosLenLong;
      crc_at       = frc_pkg::PosCrcLong;
      count        = {1'b0, pos_ff} + 9'd1;

      if (byte_valid) begin
         if (pos_ff == 8'd0) begin
            // Idle: only the start byte opens a frame.
            if (rx_byte == frc_pkg::StartByte) begin
               exp_len_in = frc_pkg::DefaultLen;
               short_in   = 1'b0;
               kind_in    = 8'h00;
               cmd_in     = 8'h00;
               type_in    = 16'h0000;
               hcrc_in    = crc8_add(frc_pkg::Crc8Init, frc_pkg::StartByte);
               fcrc_in    = frc_pkg::Crc16Init;
               last_in    = {8'h00, frc_pkg::StartByte};
               pos_in     = 8'd1;
            end
         end else begin
            if (pos_ff == frc_pkg::PosForm) begin
               short_in = rx_byte[7];
               cmd_in   = rx_byte;
            end
            len_at = short_in ? frc_pkg::PosLenShort : frc_pkg::PosLenLong;
            crc_at = short_in ? frc_pkg::PosCrcShort : frc_pkg::PosCrcLong;

            if (pos_ff == len_at) exp_len_in = rx_byte;
            if (pos_ff == frc_pkg::PosKind) kind_in = rx_byte;
            if (pos_ff == frc_pkg::PosTypeLow) type_in = {type_ff[15:8], rx_byte};
            if (pos_ff == frc_pkg::PosTypeHigh) type_in = {rx_byte, type_ff[7:0]};

            // The frame CRC trails the input by two bytes.
            if (pos_ff >= 8'd2) fcrc_in = crc16_add(fcrc_ff, last_ff[15:8]);
            last_in = {last_ff[7:0], rx_byte};

            priority if (pos_ff < crc_at) begin
               hcrc_in = crc8_add(hcrc_ff, rx_byte);
               pos_in  = count[7:0];
            end else if (pos_ff == crc_at && rx_byte != hcrc_ff) begin
               pos_in = 8'd0;
            end else begin
               pos_in = count[7:0];
            end

            // Frame completes when the count reaches the length.
            if (!(pos_ff == crc_at && rx_byte != hcrc_ff) &&
                count >= {1'b0, exp_len_in}) begin
               pos_in              = 8'd0;
               rec_valid_in        = 1'b1;
               rec_in.frame_length = exp_len_in;
               rec_in.crc16_ok     = (last_in[15:8] == fcrc_in[7:0]) &&
                                     (last_in[7:0] == fcrc_in[15:8]);
               rec_in.command_byte = cmd_in;
               rec_in.kind_byte    = kind_in;
               rec_in.type_word    = type_in;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 8'd0;
         exp_len_ff   <= frc_pkg::DefaultLen;
         short_ff     <= 1'b0;
         hcrc_ff      <= frc_pkg::Crc8Init;
         fcrc_ff      <= frc_pkg::Crc16Init;
         last_ff      <= 16'h0000;
         kind_ff      <= 8'h00;
         cmd_ff       <= 8'h00;
         type_ff      <= 16'h0000;
         rec_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         exp_len_ff   <= exp_len_in;
         short_ff     <= short_in;
         hcrc_ff      <= hcrc_in;
         fcrc_ff      <= fcrc_in;
         last_ff      <= last_in;
         kind_ff      <= kind_in;
         cmd_ff       <= cmd_in;
         type_ff      <= type_in;
         rec_valid_ff <= rec_valid_in;
      end
   end

   // Completed frame record.
   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

endmodule

`default_nettype wire

@@ design/frc_queue.sv @@
// Short queue of completed frame records between the parser and the classifier.
`default_nettype none

module frc_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire frc_pkg::frame_rec_type    wr_data,
   input  wire logic                      rd_en,
   output frc_pkg::frame_rec_type         rd_data,
   output frc_pkg::queue_status_type      status
);

   frc_pkg::frame_rec_type entry_ff [frc_pkg::QueueDepth];
   logic [frc_pkg::QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [frc_pkg::QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [frc_pkg::QueueCountW-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   // Pointer and count updates; a read and a write may share a cycle.
   always_comb begin
      do_wr     = wr_en && (count_ff != frc_pkg::QueueCountW'(frc_pkg::QueueDepth));
      do_rd     = rd_en && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == frc_pkg::QueuePtrW'(frc_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == frc_pkg::QueuePtrW'(frc_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      if (do_rd && !do_wr) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_wr) entry_ff[wr_ptr_ff] <= wr_data;
   end

   assign rd_data      = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == frc_pkg::QueueCountW'(frc_pkg::QueueDepth));

endmodule

`default_nettype wire

@@ design/frc_back.sv @@
// Classifier and result register: decodes the packet class and presents the result word.
`default_nettype none

module frc_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire frc_pkg::frame_rec_type  head,
   output logic                         head_take,
   input  wire logic                    pop,
   output logic                         empty,
   output logic [7:0]                   frame_length,
   output logic                         crc16_ok,
   output logic [3:0]                   packet_class
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] len_ff;
   logic       ok_ff;
   logic [3:0] class_ff, class_in;

   // Packet class from the form byte and the kind byte or type word.
   always_comb begin
      class_in = frc_pkg::ClassNone;
      if (head.crc16_ok) begin
         priority if (head.command_byte == frc_pkg::FormShort) begin
            priority if (head.kind_byte >= frc_pkg::KindFirst &&
                         head.kind_byte <= frc_pkg::KindLast) begin
               class_in = head.kind_byte[3:0] - frc_pkg::ClassKindBias;
            end else if (head.kind_byte == frc_pkg::KindSpecial) begin
               class_in = frc_pkg::ClassSpecial;
            end else begin
               class_in = frc_pkg::ClassOther;
            end
         end else if (head.command_byte == frc_pkg::FormLong) begin
            unique case (head.type_word)
               frc_pkg::TypeA: class_in = frc_pkg::ClassTypeA;
               frc_pkg::TypeB: class_in = frc_pkg::ClassTypeB;
               frc_pkg::TypeC: class_in = frc_pkg::ClassTypeC;
               frc_pkg::TypeD: class_in = frc_pkg::ClassTypeD;
               frc_pkg::TypeE: class_in = frc_pkg::ClassTypeE;
               default:        class_in = frc_pkg::ClassOther;
            endcase
         end else begin
            class_in = frc_pkg::ClassNone;
         end
      end
   end

   // Load a new word when the result register is free or being emptied.
   assign head_take    = head_valid && (!out_valid_ff || pop);
   assign out_valid_in = head_take || (out_valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_take) begin
         len_ff   <= head.frame_length;
         ok_ff    <= head.crc16_ok;
         class_ff <= class_in;
      end
   end

   assign empty        = !out_valid_ff;
   assign frame_length = len_ff;
   assign crc16_ok     = ok_ff;
   assign packet_class = class_ff;

endmodule

`default_nettype wire

@@ design/frame_receiver_crc_classifier_core.sv @@
// Top level of the frame receiver with header CRC8, frame CRC16 and packet classifier.
//
// Input channel: one received bus byte per word on req_rx_byte, taken at a clock edge
// where push is high and full is low. Result channel: while empty is low the oldest
// result word (rsp_frame_length, rsp_crc16_ok, rsp_packet_class) is on the ports and
// is taken at an edge where pop is high.
// The parser takes one byte every cycle while full is low; its byte CRC updates are combinational.
// A frame that completes yields its result word on the ports once it has passed the
// parser register and the queue and the result register has loaded it; while the
// result register is not popped, the record waits in the queue.
// Frames with a bad header CRC8 and idle bytes other than the start byte give no word.
// Sustained rate is one byte per cycle while the receiver keeps popping.
// When the receiver stalls, up to two finished records wait in the queue behind the
// result register; full rises only when that queue is full, so bytes keep flowing
// while results wait.
// Reset is synchronous: the parser returns to idle, the queue and result register
// empty, and both CRCs return to their initial values.
`default_nettype none

module frame_receiver_crc_classifier_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_rx_byte,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_frame_length,
   output logic            rsp_crc16_ok,
   output logic [3:0]      rsp_packet_class
);

   logic                      byte_accept;
   logic                      rec_valid;
   frc_pkg::frame_rec_type    rec;
   frc_pkg::frame_rec_type    head;
   frc_pkg::queue_status_type q_status;
   logic                      head_take;

   // Hold off bytes when the queue cannot take another record.
   assign full        = q_status.full;
   assign byte_accept = push && !q_status.full;

   frc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(byte_accept),
      .rx_byte   (req_rx_byte),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   frc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (rec_valid),
      .wr_data(rec),
      .rd_en  (head_take),
      .rd_data(head),
      .status (q_status)
   );

   frc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (!q_status.empty),
      .head        (head),
      .head_take   (head_take),
      .pop         (pop),
      .empty       (empty),
      .frame_length(rsp_frame_length),
      .crc16_ok    (rsp_crc16_ok),
      .packet_class(rsp_packet_class)
   );

   // A record never arrives at a full queue: full blocks the byte that would make one.
   assert property (@(posedge clock) disable iff (reset)
      q_status.full |=> !rec_valid)
      else $error("record written into a full queue");

   // The queue count stays within its depth.
   assert property (@(posedge clock) disable iff (reset)
      q_status.count <= frc_pkg::QueueCountW'(frc_pkg::QueueDepth))
      else $error("queue count beyond depth");

   // A failed frame CRC always carries the empty class.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_crc16_ok) |-> (rsp_packet_class == frc_pkg::ClassNone))
      else $error("class given for a frame with bad CRC16");

   // Classes stay within the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_packet_class <= frc_pkg::ClassOther))
      else $error("packet class out of range");

   // Reset leaves the result side empty.
   assert property (@(posedge clock)
      reset |=> empty)
      else $error("result present after reset");

endmodule

`default_nettype wire
